### rtl/pitb_pkg.sv
// ----------------------------------------------------------------------------
// pitb_pkg
// Shared sizes, saturation limits and request codes for the interval
// timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package pitb_pkg;

  localparam int TIMER_COUNT = 8;   // 1 .. 64
  localparam int COUNT_BITS  = 16;  // 8 .. 32

  localparam int IVL_W  = 16;
  localparam int IDX_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int CNT_W  = $clog2(TIMER_COUNT + 1);
  localparam int WIDE_W = (COUNT_BITS > IVL_W) ? COUNT_BITS : IVL_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [WIDE_W-1:0]     COUNT_MAX_W = WIDE_W'(COUNT_MAX);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

endpackage : pitb_pkg

`default_nettype wire

### rtl/periodic_interval_timer_bank.sv
// ----------------------------------------------------------------------------
// periodic_interval_timer_bank
// Bank of auto-reloading interval timers with lazy tick accounting.
// ----------------------------------------------------------------------------
// Usage notes. Ticks are only counted into one shared pending counter
// (saturating); timers are brought up to date on a check request, which
// walks every timer through a single subtractor, one timer per cycle, with
// the remaining and reload counts held in two small single-port-read
// memories. A tick, start or stop request passes through the done state
// into the output register; a check request first walks the timer memory,
// with its registered read, before the done state.
// One request is in flight at a time: in_stall stays high from accept until
// the result has been loaded into the output register. Every request
// returns exactly one result; out_expired is 1 only for a check of an
// in-range timer whose flag was set, and the flag clears as it is loaded.
// Per-entry valid bits stand in for a memory clear, so the block is ready
// right out of reset with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_interval_timer_bank
  import pitb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_op,
  input  wire logic [7:0]           in_timer_index,
  input  wire logic [IVL_W-1:0]     in_interval_ticks,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_expired
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t                 state_r, state_nxt;
  logic [COUNT_BITS-1:0]  pend_r, pend_nxt;     // shared pending ticks
  logic [COUNT_BITS-1:0]  delta_r, delta_nxt;   // ticks applied by this walk
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;       // walk read pointer
  logic                   pv_r, pv_nxt;         // read data of walk valid
  logic [IDX_W-1:0]       rd_addr_r;            // index of data in flight
  logic                   chk_r, chk_nxt;       // request is a check
  logic                   idx_ok_r, idx_ok_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TIMER_COUNT-1:0] exp_r, exp_nxt;       // expired flags
  logic [TIMER_COUNT-1:0] rem_vld_r, rem_vld_nxt;
  logic [TIMER_COUNT-1:0] rld_vld_r, rld_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_exp_r, out_exp_nxt;

  // Timer memories: remaining count and reload value per timer
  logic [COUNT_BITS-1:0]  rem_mem [TIMER_COUNT];
  logic [COUNT_BITS-1:0]  rld_mem [TIMER_COUNT];
  logic [COUNT_BITS-1:0]  rem_q_r, rld_q_r;
  logic                   rem_vq_r, rld_vq_r;

  logic                   rem_we, rld_we;
  logic [IDX_W-1:0]       rem_wa, rld_wa;
  logic [COUNT_BITS-1:0]  rem_wd, rld_wd;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic                   in_acc;
  logic                   in_idx_ok;
  logic [IDX_W-1:0]       in_idx;
  logic [WIDE_W-1:0]      ivl_w;
  logic [COUNT_BITS-1:0]  ivl_sat;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_idx_ok = (in_timer_index < 8'(TIMER_COUNT));
  assign in_idx    = in_timer_index[IDX_W-1:0];
  assign ivl_w     = WIDE_W'(in_interval_ticks);
  assign ivl_sat   = (ivl_w > COUNT_MAX_W) ? COUNT_MAX : ivl_w[COUNT_BITS-1:0];

  // --------------------------------------------------------------------------
  // Shared subtractor: remaining - delta, borrow or zero means expiry
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0]  rem_q, rld_q;
  logic [COUNT_BITS:0]    diff;
  logic                   hit;
  logic                   active;

  assign rem_q  = rem_vq_r ? rem_q_r : '0;
  assign rld_q  = rld_vq_r ? rld_q_r : '0;
  assign diff   = {1'b0, rem_q} - {1'b0, delta_r};
  assign hit    = diff[COUNT_BITS] || (diff[COUNT_BITS-1:0] == '0);
  assign active = pv_r && (delta_r != '0) && (rld_q != '0);

  assign rd_en   = (state_r == S_WALK) && (cnt_r < CNT_W'(TIMER_COUNT));
  assign rd_addr = cnt_r[IDX_W-1:0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    delta_nxt     = delta_r;
    cnt_nxt       = cnt_r;
    pv_nxt        = rd_en;
    chk_nxt       = chk_r;
    idx_ok_nxt    = idx_ok_r;
    idx_nxt       = idx_r;
    exp_nxt       = exp_r;
    rem_vld_nxt   = rem_vld_r;
    rld_vld_nxt   = rld_vld_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_exp_nxt   = out_exp_r;
    rem_we        = 1'b0;
    rem_wa        = in_idx;
    rem_wd        = ivl_sat;
    rld_we        = 1'b0;
    rld_wa        = in_idx;
    rld_wd        = ivl_sat;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          chk_nxt    = (in_op == OP_CHECK);
          idx_ok_nxt = in_idx_ok;
          idx_nxt    = in_idx;
          state_nxt  = S_DONE;
          case (in_op)
            OP_TICK: begin
              if (pend_r != COUNT_MAX) pend_nxt = pend_r + 1'b1;
            end
            OP_START: begin
              if (in_idx_ok) begin
                rem_we              = 1'b1;
                rld_we              = 1'b1;
                rem_vld_nxt[in_idx] = 1'b1;
                rld_vld_nxt[in_idx] = 1'b1;
                exp_nxt[in_idx]     = 1'b0;
              end
            end
            OP_STOP: begin
              if (in_idx_ok) begin
                rld_we              = 1'b1;
                rld_wd              = '0;
                rld_vld_nxt[in_idx] = 1'b1;
              end
            end
            default: begin
              delta_nxt = pend_r;
              pend_nxt  = '0;
              cnt_nxt   = '0;
              state_nxt = S_WALK;
            end
          endcase
        end
      end

      S_WALK: begin
        if (rd_en) cnt_nxt = cnt_r + 1'b1;
        if (active) begin
          rem_we                 = 1'b1;
          rem_wa                 = rd_addr_r;
          rem_vld_nxt[rd_addr_r] = 1'b1;
          if (hit) begin
            rem_wd             = rld_q;
            exp_nxt[rd_addr_r] = 1'b1;
          end else begin
            rem_wd = diff[COUNT_BITS-1:0];
          end
        end
        if (!rd_en && !pv_r) state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_exp_nxt   = chk_r && idx_ok_r && exp_r[idx_r];
          if (chk_r && idx_ok_r) exp_nxt[idx_r] = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= '0;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      exp_r       <= '0;
      rem_vld_r   <= '0;
      rld_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      exp_r       <= exp_nxt;
      rem_vld_r   <= rem_vld_nxt;
      rld_vld_r   <= rld_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    delta_r   <= delta_nxt;
    chk_r     <= chk_nxt;
    idx_ok_r  <= idx_ok_nxt;
    idx_r     <= idx_nxt;
    out_exp_r <= out_exp_nxt;
    if (rd_en) rd_addr_r <= rd_addr;
  end

  // --------------------------------------------------------------------------
  // Timer memories: one write, one registered read each
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rem_we) rem_mem[rem_wa] <= rem_wd;
    if (rd_en) begin
      rem_q_r  <= rem_mem[rd_addr];
      rem_vq_r <= rem_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rld_we) rld_mem[rld_wa] <= rld_wd;
    if (rd_en) begin
      rld_q_r  <= rld_mem[rd_addr];
      rld_vq_r <= rld_vld_r[rd_addr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_expired = out_exp_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pend_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == OP_CHECK) |=> (pend_r == '0))
    else $error("pending ticks not cleared by check");

  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_op == OP_CHECK) |-> ##(TIMER_COUNT + 3) (state_r == S_DONE))
    else $error("timer walk length wrong");

  a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    rem_we && rd_en |-> (rem_wa != rd_addr))
    else $error("write and read of same timer in one cycle");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside of done state");

endmodule : periodic_interval_timer_bank

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for periodic_interval_timer_bank. A model of the
// timer bank, kept inside the bench, predicts the expired bit of every
// request: a shared saturating pending-tick count, and per-timer remaining,
// reload and expired state that is brought up to date on each check. Named
// tests run in turn: directed cases first, then about a thousand random
// requests. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pitb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT ports
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;

  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_op;
  logic [7:0]       in_timer_index;
  logic [IVL_W-1:0] in_interval_ticks;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_expired;

  always #10 clk = ~clk;   // 20 ns period

  periodic_interval_timer_bank u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_timer_index    (in_timer_index),
    .in_interval_ticks (in_interval_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_expired       (out_expired)
  );

  // --------------------------------------------------------------------------
  // Timer bank model state. Widths follow the block, except that the
  // remaining count carries one extra bit that the design does not have.
  // --------------------------------------------------------------------------
  logic [COUNT_BITS-1:0] pend_ticks;
  logic [COUNT_BITS:0]   remain_cnt   [TIMER_COUNT];
  logic [COUNT_BITS-1:0] reload_cnt   [TIMER_COUNT];
  logic                  expired_flag [TIMER_COUNT];

  // Expired bits still owed by the DUT, oldest first.
  logic expected_expired [$];

  int   error_count = 0;
  bit   idle_en     = 1'b1;   // random gaps on both channels when set
  int   stall_left  = 0;

  // Bring every running timer up to date with the pending ticks. Timers
  // whose reload value is zero are stopped and keep their state.
  function automatic void apply_pending_ticks();
    logic [COUNT_BITS-1:0] delta;
    delta      = pend_ticks;
    pend_ticks = '0;
    if (delta != '0) begin
      for (int t = 0; t < TIMER_COUNT; t++) begin
        if (reload_cnt[t] != '0) begin
          if ({1'b0, delta} >= remain_cnt[t]) begin
            remain_cnt[t]   = {1'b0, reload_cnt[t]};
            expired_flag[t] = 1'b1;
          end else begin
            remain_cnt[t] = remain_cnt[t] - {1'b0, delta};
          end
        end
      end
    end
  endfunction

  // Update the model with one accepted request and return its expired bit.
  function automatic logic predict_expiry(op_t op, logic [7:0] idx,
                                          logic [IVL_W-1:0] ivl);
    logic                  in_range;
    logic [IDX_W-1:0]      slot;
    logic [WIDE_W-1:0]     wide_ivl;
    logic [COUNT_BITS-1:0] load_val;
    logic                  hit;
    in_range = (int'(idx) < TIMER_COUNT);
    slot     = idx[IDX_W-1:0];
    hit      = 1'b0;
    // An interval beyond the count range clamps to the count maximum.
    wide_ivl = WIDE_W'(ivl);
    if (wide_ivl > COUNT_MAX_W) wide_ivl = COUNT_MAX_W;
    load_val = COUNT_BITS'(wide_ivl);
    case (op)
      OP_TICK: begin
        // Saturating: a tick at the maximum is dropped.
        if (pend_ticks != COUNT_MAX) pend_ticks = pend_ticks + 1'b1;
      end
      OP_START: begin
        if (in_range) begin
          expired_flag[slot] = 1'b0;
          remain_cnt[slot]   = {1'b0, load_val};
          reload_cnt[slot]   = load_val;
        end
      end
      OP_STOP: begin
        // Only the reload value goes; remaining count and flag stay.
        if (in_range) reload_cnt[slot] = '0;
      end
      default: begin
        apply_pending_ticks();
        if (in_range && expired_flag[slot]) begin
          expired_flag[slot] = 1'b0;
          hit = 1'b1;
        end
      end
    endcase
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Called at a rising edge; returns at the edge where the
  // request is accepted, with in_valid still high so a back-to-back request
  // needs only one assignment in that step.
  // --------------------------------------------------------------------------
  task automatic send_request(op_t op, logic [7:0] idx, logic [IVL_W-1:0] ivl);
    int gap;
    gap = idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_timer_index    <= idx;
    in_interval_ticks <= ivl;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_expired.push_back(predict_expiry(op, idx, ivl));
  endtask

  // --------------------------------------------------------------------------
  // Result side: compare each delivered result against the oldest
  // prediction, then draw the stall for the next one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_expired.size() == 0) begin
        $error("result with no request outstanding: expired=%0b", out_expired);
        error_count++;
      end else begin
        logic exp_bit;
        exp_bit = expected_expired.pop_front();
        if (out_expired !== exp_bit) begin
          $error("expired: expected %0b, actual %0b", exp_bit, out_expired);
          error_count++;
        end
      end
      stall_left = idle_en ? $urandom_range(0, 6) : 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Right after reset nothing has expired, in or out of range, and a check
  // with nothing pending leaves the bank alone.
  task automatic test_reset_state();
    send_request(OP_CHECK, 8'd0,   16'h0000);
    send_request(OP_CHECK, 8'd7,   16'hFFFF);
    send_request(OP_CHECK, 8'd255, 16'h0000);
  endtask

  // Expiry on the exact tick, flag cleared by the check that reports it,
  // and reload of the period after expiry.
  task automatic test_expiry_and_reload();
    send_request(OP_START, 8'd0, 16'd1);
    send_request(OP_TICK,  8'd0, 16'd0);
    send_request(OP_CHECK, 8'd0, 16'd0);
    send_request(OP_CHECK, 8'd0, 16'd0);
    send_request(OP_START, 8'd3, 16'd3);
    send_request(OP_TICK,  8'd3, 16'd0);
    send_request(OP_TICK,  8'd3, 16'd0);
    send_request(OP_CHECK, 8'd3, 16'd0);   // one tick short
    send_request(OP_TICK,  8'd3, 16'd0);
    send_request(OP_CHECK, 8'd3, 16'd0);
  endtask

  // A start with interval zero leaves the timer stopped and its flag clear.
  task automatic test_zero_interval();
    send_request(OP_START, 8'd2, 16'd0);
    send_request(OP_TICK,  8'd2, 16'hFFFF);
    send_request(OP_CHECK, 8'd2, 16'd0);
  endtask

  // Stop drops only the reload value: a flag set before the stop survives,
  // and the stopped timer no longer expires.
  task automatic test_stop_keeps_flag();
    send_request(OP_START, 8'd4, 16'd2);
    send_request(OP_TICK,  8'd4, 16'd0);
    send_request(OP_TICK,  8'd4, 16'd0);
    send_request(OP_CHECK, 8'd1, 16'd0);   // applies ticks, timer 4 expires
    send_request(OP_STOP,  8'd4, 16'd0);
    send_request(OP_CHECK, 8'd4, 16'd0);
    send_request(OP_TICK,  8'd4, 16'd0);
    send_request(OP_TICK,  8'd4, 16'd0);
    send_request(OP_CHECK, 8'd4, 16'd0);
  endtask

  // Out-of-range indices: start and stop do nothing, check still applies
  // the pending ticks and reports zero.
  task automatic test_out_of_range();
    send_request(OP_START, 8'd8,   16'd5);
    send_request(OP_STOP,  8'd255, 16'hFFFF);
    send_request(OP_TICK,  8'd200, 16'd0);
    send_request(OP_CHECK, 8'd8,   16'd0);
  endtask

  // A long run of ticks applied by one check: timer 7 overshoots its
  // period and reloads, timer 6 is left part way down its count.
  task automatic test_pending_accumulation();
    send_request(OP_START, 8'd7, 16'd40);
    send_request(OP_START, 8'd6, 16'd200);
    for (int n = 0; n < 100; n++)
      send_request(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom));
    send_request(OP_CHECK, 8'd7, 16'd0);
    send_request(OP_CHECK, 8'd7, 16'd0);
    send_request(OP_CHECK, 8'd6, 16'd0);
  endtask

  // Random traffic. Mostly in-range timers with short periods so expiries
  // are frequent; a tenth of the indices and a quarter of the intervals
  // span the whole field. Idling switches on and off every hundred requests.
  task automatic test_random_traffic();
    int               pick;
    op_t              op;
    logic [7:0]       idx;
    logic [IVL_W-1:0] ivl;
    for (int n = 0; n < 1000; n++) begin
      if (n % 100 == 0) idle_en = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_TICK;
      else if (pick < 55) op = OP_START;
      else if (pick < 62) op = OP_STOP;
      else                op = OP_CHECK;
      if ($urandom_range(0, 9) == 0) idx = 8'($urandom_range(0, 255));
      else                           idx = 8'($urandom_range(0, TIMER_COUNT - 1));
      pick = $urandom_range(0, 99);
      if (pick < 10)      ivl = '0;
      else if (pick < 75) ivl = IVL_W'($urandom_range(1, 24));
      else                ivl = IVL_W'($urandom);
      send_request(op, idx, ivl);
    end
    idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_op             = OP_TICK;
    in_timer_index    = '0;
    in_interval_ticks = '0;

    pend_ticks = '0;
    for (int t = 0; t < TIMER_COUNT; t++) begin
      remain_cnt[t]   = '0;
      reload_cnt[t]   = '0;
      expired_flag[t] = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_state();
    test_expiry_and_reload();
    test_zero_interval();
    test_stop_keeps_flag();
    test_out_of_range();
    test_pending_accumulation();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_expired.size() != 0) @(posedge clk);
    // A check is the longest request; allow for a stray extra result.
    repeat (TIMER_COUNT + 20) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule : tb_top

`default_nettype wire
